// ===== rtl/utf8_char_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 character decoder assertion macros
// Shared assertion forms for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef UTF8_CHAR_DECODER_TOP_DEFINES_SVH
`define UTF8_CHAR_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define UTF8D_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UTF8D_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 character decoder package
// Transfer types, status codes and lead-byte helper functions.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_SHORT    = 3'd2,
      ST_ILLEGAL  = 3'd3,
      ST_BADCONT  = 3'd4,
      ST_OVERLONG = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] byte_0;
      logic [7:0] byte_1;
      logic [7:0] byte_2;
      logic [7:0] byte_3;
      logic [7:0] byte_4;
      logic [7:0] byte_5;
      logic [2:0] avail_bytes;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  used_bytes;
      logic [30:0] code_point;
   } rsp_type;

   // Result of the lead-byte stage.
   typedef struct packed {
      status_type      status;
      logic [2:0]      len;
      logic [6:0]      lead_bits;
      logic [4:0]      cont_ok;
      logic [4:0][5:0] cont_bits;
   } lead_info_type;

   function automatic logic [2:0] seq_length(input logic [7:0] lead);
      logic [2:0] len;
      len = 3'd0;
      if (lead[7] == 1'b0) begin
         len = 3'd1;
      end else if (lead[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (lead[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (lead[7:3] == 5'b11110) begin
         len = 3'd4;
      end else if (lead[7:2] == 6'b111110) begin
         len = 3'd5;
      end else if (lead[7:1] == 7'b1111110) begin
         len = 3'd6;
      end
      return len;
   endfunction

   function automatic logic [6:0] lead_mask(input logic [2:0] len);
      logic [6:0] mask;
      case (len)
         3'd1: mask = 7'h7f;
         3'd2: mask = 7'h1f;
         3'd3: mask = 7'h0f;
         3'd4: mask = 7'h07;
         3'd5: mask = 7'h03;
         3'd6: mask = 7'h01;
         default: mask = 7'h00;
      endcase
      return mask;
   endfunction

   function automatic logic [30:0] min_value(input logic [2:0] len);
      logic [30:0] limit;
      case (len)
         3'd2: limit = 31'h80;
         3'd3: limit = 31'h800;
         3'd4: limit = 31'h10000;
         3'd5: limit = 31'h200000;
         3'd6: limit = 31'h4000000;
         default: limit = 31'h0;
      endcase
      return limit;
   endfunction

endpackage

// ===== rtl/utf8d_lead_stage.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder lead-byte stage
// Classifies the lead byte, applies the empty, illegal and length checks and
// registers the payload bits of every byte for the assembly stage.
// ----------------------------------------------------------------------------
module utf8d_lead_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  utf8d_pkg::req_type      req,
   output logic                    out_valid,
   output utf8d_pkg::lead_info_type out_info
);
   import utf8d_pkg::*;

   logic          valid_ff;
   lead_info_type info_ff;
   lead_info_type info_in;
   logic [2:0]    avail_sat;
   logic [2:0]    len;
   logic [4:0][7:0] conts;

   always_comb begin
      conts     = {req.byte_5, req.byte_4, req.byte_3, req.byte_2, req.byte_1};
      avail_sat = (req.avail_bytes == 3'd7) ? 3'd6 : req.avail_bytes;
      len       = seq_length(req.byte_0);

      info_in.len       = len;
      info_in.lead_bits = req.byte_0[6:0] & lead_mask(len);
      for (int i = 0; i < 5; i++) begin
         info_in.cont_ok[i]   = (conts[i][7:6] == 2'b10);
         info_in.cont_bits[i] = conts[i][5:0];
      end

      if (avail_sat == 3'd0) begin
         info_in.status = ST_EMPTY;
      end else if (len == 3'd0) begin
         info_in.status = ST_ILLEGAL;
      end else if (avail_sat < len) begin
         info_in.status = ST_SHORT;
      end else begin
         info_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      info_ff <= info_in;
   end

   assign out_valid = valid_ff;
   assign out_info  = info_ff;

endmodule

// ===== rtl/utf8_char_decoder_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 character decoder
// Decodes one character of up to six bytes in the original UTF-8 form.
//
//   Channel   Direction  Handshake               Payload
//   request   in         start high, busy low    req_data (req_type)
//   response  out        rsp_strobe, one cycle   rsp_data (rsp_type)
//
// One window is accepted on every clock cycle; busy is never raised.
// Each result reaches the response ports through the lead-byte, assembly and
// range-check register stages, in that order.
// Reset clears only the valid bits of the pipeline; no result follows reset.
// The receiver cannot stall, so the pipeline advances on every cycle.
// ----------------------------------------------------------------------------
`include "utf8_char_decoder_top_defines.svh"

module utf8_char_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  utf8d_pkg::req_type req_data,
   output logic               rsp_strobe,
   output utf8d_pkg::rsp_type rsp_data
);
   import utf8d_pkg::*;

   logic          s1_valid;
   lead_info_type s1_info;

   logic          s2_valid_ff;
   status_type    s2_status_ff;
   status_type    s2_status_in;
   logic [2:0]    s2_len_ff;
   logic [30:0]   s2_value_ff;
   logic [30:0]   s2_value_in;
   logic          cont_bad;

   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   assign busy = 1'b0;

   utf8d_lead_stage u_lead (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .req       (req_data),
      .out_valid (s1_valid),
      .out_info  (s1_info)
   );

   always_comb begin
      cont_bad = 1'b0;
      for (int i = 0; i < 5; i++) begin
         if ((3'(i + 1) < s1_info.len) && !s1_info.cont_ok[i]) begin
            cont_bad = 1'b1;
         end
      end
      if (s1_info.status == ST_OK && cont_bad) begin
         s2_status_in = ST_BADCONT;
      end else begin
         s2_status_in = s1_info.status;
      end

      case (s1_info.len)
         3'd1: s2_value_in = {24'd0, s1_info.lead_bits};
         3'd2: s2_value_in = {20'd0, s1_info.lead_bits[4:0], s1_info.cont_bits[0]};
         3'd3: s2_value_in = {15'd0, s1_info.lead_bits[3:0], s1_info.cont_bits[0],
                              s1_info.cont_bits[1]};
         3'd4: s2_value_in = {10'd0, s1_info.lead_bits[2:0], s1_info.cont_bits[0],
                              s1_info.cont_bits[1], s1_info.cont_bits[2]};
         3'd5: s2_value_in = {5'd0, s1_info.lead_bits[1:0], s1_info.cont_bits[0],
                              s1_info.cont_bits[1], s1_info.cont_bits[2],
                              s1_info.cont_bits[3]};
         3'd6: s2_value_in = {s1_info.lead_bits[0], s1_info.cont_bits[0],
                              s1_info.cont_bits[1], s1_info.cont_bits[2],
                              s1_info.cont_bits[3], s1_info.cont_bits[4]};
         default: s2_value_in = 31'd0;
      endcase
   end

   always_comb begin
      if (s2_status_ff != ST_OK) begin
         rsp_in.status     = s2_status_ff;
         rsp_in.used_bytes = 3'd0;
         rsp_in.code_point = 31'd0;
      end else if (s2_value_ff < min_value(s2_len_ff)) begin
         rsp_in.status     = ST_OVERLONG;
         rsp_in.used_bytes = 3'd0;
         rsp_in.code_point = 31'd0;
      end else begin
         rsp_in.status     = ST_OK;
         rsp_in.used_bytes = s2_len_ff;
         rsp_in.code_point = s2_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s1_valid;
         rsp_valid_ff <= s2_valid_ff;
      end
      s2_status_ff <= s2_status_in;
      s2_len_ff    <= s1_info.len;
      s2_value_ff  <= s2_value_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `UTF8D_ASSERT_IMPL(a_rsp_has_transfer, clock, reset, rsp_strobe, $past(start, 3),
                      "Result without a matching request transfer.")
   `UTF8D_ASSERT_NEXT(a_stage_flow, clock, reset, s2_valid_ff, rsp_strobe,
                      "Assembly stage item did not reach the output.")
   `UTF8D_ASSERT_IMPL(a_error_zero, clock, reset,
                      rsp_strobe && (rsp_data.status != ST_OK),
                      (rsp_data.used_bytes == 3'd0) && (rsp_data.code_point == 31'd0),
                      "Error result carries a non-zero count or code point.")
   `UTF8D_ASSERT_IMPL(a_ok_count, clock, reset,
                      rsp_strobe && (rsp_data.status == ST_OK),
                      (rsp_data.used_bytes != 3'd0) && (rsp_data.used_bytes <= 3'd6),
                      "Successful result has an impossible byte count.")

endmodule
